/* rtl/run_length_level_decoder_core_macros.svh */
// assertion helpers shared by the rlld modules
`ifndef RUN_LENGTH_LEVEL_DECODER_CORE_MACROS_SVH
`define RUN_LENGTH_LEVEL_DECODER_CORE_MACROS_SVH

// property must hold at every edge outside reset
`define RLLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define RLLD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/rlld_pkg.sv */
package rlld_pkg;

  localparam int LEVEL_DEPTH   = 256;
  localparam int LEVEL_AW      = 8;
  localparam int MAX_CODE_BITS = 16;
  localparam int COUNT_W       = 33;
  localparam int PROD_W        = COUNT_W + MAX_CODE_BITS;
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_AW       = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CODE = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_LEVEL  = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_TOTAL     = 3'd3;
  localparam logic [2:0] ST_BAD_PARAM = 3'd4;

  localparam logic [1:0] CFG_CODE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_MAX_LEVEL    = 2'd1;
  localparam logic [1:0] CFG_LEVEL_COUNT  = 2'd2;
  localparam logic [1:0] CFG_TOTAL_VALUES = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  table_index;
    logic [15:0] table_value;
    logic [15:0] code;
    logic        final_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  level_index;
    logic [15:0] table_level;
    logic [31:0] run_length;
    logic        done_res;
    logic [2:0]  status;
  } out_item_t;

  // result before the table lookup
  typedef struct packed {
    logic [7:0]  level_index;
    logic [31:0] run_length;
    logic        done_res;
    logic [2:0]  status;
  } run_t;

  typedef struct packed {
    logic      v0;
    logic      v1;
    out_item_t o0;
    out_item_t o1;
  } res_pair_t;

  typedef struct packed {
    logic [4:0]  code_width;
    logic [7:0]  max_level;
    logic [7:0]  level_count;
    logic [31:0] total_values;
  } cfg_t;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] sat_mul(input logic [COUNT_W-1:0] a,
                                                 input logic [MAX_CODE_BITS-1:0] b);
    logic [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b);
    return (|p[PROD_W-1:COUNT_W]) ? COUNT_MAX : p[COUNT_W-1:0];
  endfunction

endpackage

/* rtl/rlld_engine.sv */
`include "run_length_level_decoder_core_macros.svh"

module rlld_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  rlld_pkg::cfg_t       cfg,
  input  logic                 item_valid,
  input  rlld_pkg::in_item_t   item,
  output rlld_pkg::res_pair_t  res
);
  import rlld_pkg::*;

  logic [15:0]        level_store [LEVEL_DEPTH];
  logic [15:0]        rd0;
  logic [15:0]        rd1;

  logic [7:0]         pend_level;
  logic [COUNT_W-1:0] pend_count;
  logic [COUNT_W-1:0] weight;
  logic               run_open;
  logic [COUNT_W-1:0] emitted;
  logic [2:0]         err;

  logic [7:0]         pend_level_next;
  logic [COUNT_W-1:0] pend_count_next;
  logic [COUNT_W-1:0] weight_next;
  logic               run_open_next;
  logic [COUNT_W-1:0] emitted_next;
  logic [2:0]         err_next;

  logic               v0_next;
  logic               v1_next;
  run_t               r0_next;
  run_t               r1_next;
  logic               v0;
  logic               v1;
  run_t               r0;
  run_t               r1;

  logic [16:0]        full;
  logic [15:0]        code_m;
  logic [15:0]        range_val;
  logic [15:0]        digit;
  logic [COUNT_W-1:0] tv33;
  logic [COUNT_W-1:0] prod_c;
  logic [COUNT_W-1:0] prod_w;
  logic [COUNT_W-1:0] sum;
  logic               bad;
  logic               is_level;
  logic               do_code;
  logic [2:0]         e;
  logic [LEVEL_AW-1:0] addr0;
  logic [LEVEL_AW-1:0] addr1;

  always_comb begin
    full      = 17'((17'd1 << cfg.code_width) - 17'd1);
    code_m    = item.code & full[15:0];
    range_val = 16'(full - {9'd0, cfg.max_level});
    digit     = code_m - {8'd0, cfg.max_level} - 16'd1;
    tv33      = {1'b0, cfg.total_values};
    bad       = (cfg.code_width == 5'd0) || (cfg.code_width > 5'(MAX_CODE_BITS)) ||
                (cfg.level_count == 8'd0) || (cfg.max_level > cfg.level_count) ||
                (full <= {9'd0, cfg.max_level});
    is_level  = code_m <= {8'd0, cfg.max_level};
    prod_c    = sat_mul(weight, digit);
    prod_w    = sat_mul(weight, range_val);
    do_code   = item_valid && (item.opcode == OP_CODE);

    pend_level_next = pend_level;
    pend_count_next = pend_count;
    weight_next     = weight;
    run_open_next   = run_open;
    emitted_next    = emitted;
    e               = err;
    v0_next         = 1'b0;
    v1_next         = 1'b0;
    r0_next         = '0;
    r1_next         = '0;
    sum             = '0;

    if (do_code) begin
      if (e == ST_OK && cfg.max_level != 8'd0) begin
        if (bad) begin
          e = ST_BAD_PARAM;
        end else if (is_level) begin
          if (run_open) begin
            if (pend_count > tv33) begin
              e = ST_TOO_LONG;
            end else begin
              v0_next      = 1'b1;
              r0_next      = '{pend_level, pend_count[31:0], 1'b0, ST_OK};
              emitted_next = sat_add(emitted, pend_count);
            end
          end
          if (e == ST_OK) begin
            pend_level_next = code_m[7:0];
            pend_count_next = COUNT_W'(1);
            weight_next     = COUNT_W'(1);
            run_open_next   = 1'b1;
          end
        end else if (!run_open) begin
          e = ST_NO_LEVEL;
        end else begin
          pend_count_next = sat_add(pend_count, prod_c);
          weight_next     = prod_w;
        end
      end

      if (item.final_code) begin
        v1_next = 1'b1;
        if (e == ST_OK && cfg.max_level == 8'd0) begin
          r1_next = '{8'd0, cfg.total_values, 1'b1, ST_OK};
        end else begin
          if (e == ST_OK && run_open_next && pend_count_next > tv33) begin
            e = ST_TOO_LONG;
          end
          if (e == ST_OK) begin
            sum = run_open_next ? sat_add(emitted_next, pend_count_next) : emitted_next;
            r1_next = '{run_open_next ? pend_level_next : 8'd0,
                        run_open_next ? pend_count_next[31:0] : 32'd0,
                        1'b1,
                        (sum != tv33) ? ST_TOTAL : ST_OK};
          end else begin
            r1_next = '{8'd0, 32'd0, 1'b1, e};
          end
        end
        // section closes: everything but table and registers goes back
        pend_level_next = '0;
        pend_count_next = '0;
        weight_next     = COUNT_W'(1);
        run_open_next   = 1'b0;
        emitted_next    = '0;
        e               = ST_OK;
      end
    end
    err_next = e;
    addr0    = pend_level - 8'd1;
    addr1    = r1_next.level_index - 8'd1;
  end

  // table port: one write, two registered reads
  always_ff @(posedge clk) begin
    if (item_valid && item.opcode == OP_LOAD) begin
      level_store[item.table_index] <= item.table_value;
    end
    rd0 <= level_store[addr0];
    rd1 <= level_store[addr1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_level <= '0;
      pend_count <= '0;
      weight     <= COUNT_W'(1);
      run_open   <= 1'b0;
      emitted    <= '0;
      err        <= ST_OK;
      v0         <= 1'b0;
      v1         <= 1'b0;
    end else begin
      pend_level <= pend_level_next;
      pend_count <= pend_count_next;
      weight     <= weight_next;
      run_open   <= run_open_next;
      emitted    <= emitted_next;
      err        <= err_next;
      v0         <= v0_next;
      v1         <= v1_next;
    end
  end

  always_ff @(posedge clk) begin
    r0 <= r0_next;
    r1 <= r1_next;
  end

  always_comb begin
    res.v0 = v0;
    res.v1 = v1;
    res.o0 = '{r0.level_index, (r0.level_index == 8'd0) ? 16'd0 : rd0,
               r0.run_length, r0.done_res, r0.status};
    res.o1 = '{r1.level_index, (r1.level_index == 8'd0) ? 16'd0 : rd1,
               r1.run_length, r1.done_res, r1.status};
  end

  `RLLD_ASSERT(a_section_clear, do_code && item.final_code |=> !run_open && err == ST_OK, "section state not cleared after final code")
  `RLLD_NEVER(a_run_not_done, v0 && r0.done_res, "closed run marked as section end")
  `RLLD_NEVER(a_run_status_ok, v0 && r0.status != ST_OK, "closed run carries an error status")

endmodule

/* rtl/rlld_res_fifo.sv */
`include "run_length_level_decoder_core_macros.svh"

module rlld_res_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  rlld_pkg::res_pair_t  res,
  output logic [rlld_pkg::FIFO_AW:0] count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rlld_pkg::out_item_t  out_item
);
  import rlld_pkg::*;

  out_item_t          entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   push_n;
  logic               pop;

  always_comb begin
    push_n    = (FIFO_AW+1)'(res.v0) + (FIFO_AW+1)'(res.v1);
    out_valid = count != '0;
    pop       = out_valid && out_ready;
    out_item  = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (res.v0) begin
      entries[wr_ptr] <= res.o0;
      if (res.v1) begin
        entries[wr_ptr + FIFO_AW'(1)] <= res.o1;
      end
    end else if (res.v1) begin
      entries[wr_ptr] <= res.o1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[FIFO_AW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + push_n - (FIFO_AW+1)'(pop);
    end
  end

  `RLLD_NEVER(a_no_overflow, count + push_n > (FIFO_AW+1)'(FIFO_DEPTH), "result queue overflow")

endmodule

/* rtl/run_length_level_decoder_core.sv */
// a result passes the input register, the step register and the queue before it is offered
// throughput: one item per cycle while in_ready is high; the output side moves one result per
// cycle, so two-result items are limited by the result port and the 8-entry queue credit
// reset (rst, synchronous): config back to defaults, section state, pipeline and queue cleared
// the level table is not cleared and holds unknown data until loaded
`include "run_length_level_decoder_core_macros.svh"

module run_length_level_decoder_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rlld_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rlld_pkg::out_item_t  out_item
);
  import rlld_pkg::*;

  cfg_t             cfg;
  logic             in_v;
  in_item_t         in_q;
  res_pair_t        res;
  logic [FIFO_AW:0] fifo_count;
  logic [FIFO_AW+1:0] occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_width   <= 5'd8;
      cfg.max_level    <= 8'd1;
      cfg.level_count  <= 8'd1;
      cfg.total_values <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CODE_WIDTH:   cfg.code_width   <= cfg_data[4:0];
        CFG_MAX_LEVEL:    cfg.max_level    <= cfg_data[7:0];
        CFG_LEVEL_COUNT:  cfg.level_count  <= cfg_data[7:0];
        CFG_TOTAL_VALUES: cfg.total_values <= cfg_data;
        default: ;
      endcase
    end
  end

  // credit: every result that may still land in the queue is counted
  always_comb begin
    occ = (FIFO_AW+2)'(fifo_count) + (FIFO_AW+2)'(res.v0) + (FIFO_AW+2)'(res.v1) +
          (in_v ? (FIFO_AW+2)'(2) : (FIFO_AW+2)'(0));
    in_ready = occ + (FIFO_AW+2)'(2) <= (FIFO_AW+2)'(FIFO_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
  end

  rlld_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_v),
    .item       (in_q),
    .res        (res)
  );

  rlld_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .count     (fifo_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  `RLLD_NEVER(a_credit_bound, occ > (FIFO_AW+2)'(FIFO_DEPTH), "results in flight exceed queue depth")

endmodule
